// ----- hdl/aclp_pkg.sv -----
// ----------------------------------------------------------------------------
// aclp_pkg: shared types and constants of the ASCII command line parser
// Character codes, line limits, the command table and the beat format that
// travels from the byte classifier through the queue to the parser core.
// ----------------------------------------------------------------------------
`default_nettype none

package aclp_pkg;

    // Line format limits
    localparam int ARG_BYTES  = 8;     // most hex digits in an argument (1..8)
    localparam int LINE_LIMIT = 64;    // byte at LINE_LIMIT-1 always rejects (8..64)

    localparam int POS_W = $clog2(LINE_LIMIT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LIMIT - 1);

    localparam int DC_W = 6;           // digit count saturates at 63
    localparam logic [DC_W-1:0] DC_MAX   = {DC_W{1'b1}};
    localparam logic [DC_W-1:0] DC_LIMIT = DC_W'(ARG_BYTES);

    localparam int ARG_W = 32;
    localparam int IDX_W = 5;
    localparam int CMD_COUNT = 20;

    // Queue between classifier and parser core
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;

    // Command table: dd de ds dw ee eo gw ll lo mm mo lq pd pe ps pw zd ze zr zw
    localparam logic [7:0] CMD_FIRST [CMD_COUNT] = '{
        "d", "d", "d", "d", "e", "e", "g", "l", "l", "m",
        "m", "l", "p", "p", "p", "p", "z", "z", "z", "z"
    };
    localparam logic [7:0] CMD_SECOND [CMD_COUNT] = '{
        "d", "e", "s", "w", "e", "o", "w", "l", "o", "m",
        "o", "q", "d", "e", "s", "w", "d", "e", "r", "w"
    };

    typedef enum logic [1:0] {
        PH_LETTERS,
        PH_GAP,
        PH_DIGITS,
        PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        VERD_NONE,
        VERD_ACCEPT,
        VERD_REJECT
    } verdict_t;

    // One classified byte
    typedef struct packed {
        logic [7:0] ch;
        logic       line_start;
        logic       is_lower;
        logic       is_space;
        logic       is_end;
        logic       is_hex;
        logic [3:0] hex_val;
    } char_item_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } cmd_match_t;

    // First table position whose letters match
    function automatic cmd_match_t cmd_lookup(input logic [7:0] first,
                                              input logic [7:0] second);
        cmd_match_t res;
        res.hit = 1'b0;
        res.idx = '0;
        for (int i = CMD_COUNT - 1; i >= 0; i--) begin
            if (CMD_FIRST[i] == first && CMD_SECOND[i] == second) begin
                res.hit = 1'b1;
                res.idx = IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ascii_command_line_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_command_line_parser: two-letter command line parser
// Parses "cc <spaces> HEX <spaces> CR|LF" lines one byte per beat and
// returns one verdict per line: command table position and hex argument.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready): one byte per beat on s_char_in; raise
// s_line_start on the first byte of each line to restart the parser.
// Output channel (m_valid/m_ready): one beat per line, given on the byte at
// which the line is accepted or rejected; on reject m_accepted is low and
// m_command_index and m_argument read zero. Bytes after a verdict are
// dropped until the next start flag; a start flag in mid line abandons
// that line without a result.
// Throughput: one byte per cycle while no result waits on m_ready, set
// by the combinational grammar step in the parser core.
// Result path: a taken byte is first stored in the queue; the core then
// pops it and registers the verdict, which raises m_valid.
// Reset: synchronous, active low; the queue empties, no result is pending
// and the parser waits for a start flag.
// Stalls: while a result waits on m_ready the core holds; the four-entry
// queue keeps taking bytes until it fills, then s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_command_line_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_char_in,
    input  wire logic                          s_line_start,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_accepted,
    output logic [aclp_pkg::IDX_W-1:0]         m_command_index,
    output logic [aclp_pkg::ARG_W-1:0]         m_argument
);

    aclp_pkg::char_item_t in_item;
    aclp_pkg::char_item_t q_item;
    logic                 q_valid;
    logic                 q_pop;
    logic                 push;

    // Classify the incoming byte
    aclp_front u_front (
        .char_in    (s_char_in),
        .line_start (s_line_start),
        .item       (in_item)
    );

    assign push = s_valid && s_ready;

    // Hold classified beats until the core is free
    aclp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (in_item),
        .not_full  (s_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    // Advance the grammar and hold the verdict
    aclp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_command_index (m_command_index),
        .m_argument      (m_argument)
    );

endmodule

`default_nettype wire

// ----- hdl/aclp_front.sv -----
// ----------------------------------------------------------------------------
// aclp_front: byte classifier
// Sorts each incoming byte into the classes the parser needs and decodes
// its hex digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module aclp_front (
    input  wire logic [7:0]          char_in,
    input  wire logic                line_start,
    output aclp_pkg::char_item_t     item
);

    logic is_digit;
    logic is_hex_up;

    assign is_digit  = char_in inside {[aclp_pkg::CH_0:aclp_pkg::CH_9]};
    assign is_hex_up = char_in inside {[aclp_pkg::CH_A_UP:aclp_pkg::CH_F_UP]};

    always_comb begin
        item.ch         = char_in;
        item.line_start = line_start;
        item.is_lower   = char_in inside {[aclp_pkg::CH_A_LO:aclp_pkg::CH_Z_LO]};
        item.is_space   = (char_in == aclp_pkg::CH_SPACE);
        item.is_end     = (char_in == aclp_pkg::CH_LF) || (char_in == aclp_pkg::CH_CR);
        item.is_hex     = is_digit || is_hex_up;
        // 'A'..'F' have low nibble 1..6: add 9 to get 10..15
        item.hex_val    = is_digit ? char_in[3:0] : (char_in[3:0] + 4'd9);
    end

endmodule

`default_nettype wire

// ----- hdl/aclp_queue.sv -----
// ----------------------------------------------------------------------------
// aclp_queue: classified byte queue
// Short FIFO between the classifier and the parser core so that the input
// side and the result side stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module aclp_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire aclp_pkg::char_item_t  push_item,
    output logic                       not_full,
    input  wire logic                  pop,
    output logic                       not_empty,
    output aclp_pkg::char_item_t       pop_item
);

    aclp_pkg::char_item_t slots_reg [aclp_pkg::QUEUE_DEPTH];

    logic [aclp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [aclp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [aclp_pkg::QCNT_W-1:0] count_reg,  count_next;

    localparam logic [aclp_pkg::QPTR_W-1:0] PTR_LAST =
        aclp_pkg::QPTR_W'(aclp_pkg::QUEUE_DEPTH - 1);
    localparam logic [aclp_pkg::QCNT_W-1:0] CNT_FULL =
        aclp_pkg::QCNT_W'(aclp_pkg::QUEUE_DEPTH);

    assign not_full  = (count_reg != CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_item  = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- hdl/aclp_back.sv -----
// ----------------------------------------------------------------------------
// aclp_back: parser core
// Steps the line grammar one classified byte at a time and holds the
// verdict of each line in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module aclp_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire aclp_pkg::char_item_t          q_item,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_accepted,
    output logic [aclp_pkg::IDX_W-1:0]         m_command_index,
    output logic [aclp_pkg::ARG_W-1:0]         m_argument
);

    aclp_pkg::phase_t                  phase_reg, phase_next;
    logic [aclp_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [7:0]                        first_reg, first_next;
    logic [7:0]                        second_reg, second_next;
    logic [aclp_pkg::DC_W-1:0]         dc_reg, dc_next;
    logic [aclp_pkg::ARG_W-1:0]        acc_reg, acc_next;
    logic [aclp_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                              done_reg, done_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              out_acc_reg;
    logic [aclp_pkg::IDX_W-1:0]        out_idx_reg;
    logic [aclp_pkg::ARG_W-1:0]        out_arg_reg;

    // State as seen after a possible restart by the start flag
    aclp_pkg::phase_t                  ph_e;
    logic [aclp_pkg::POS_W-1:0]        pos_e;
    logic [7:0]                        first_e, second_e;
    logic [aclp_pkg::DC_W-1:0]         dc_e;
    logic [aclp_pkg::ARG_W-1:0]        acc_e;
    logic [aclp_pkg::IDX_W-1:0]        idx_e;
    logic                              done_e;

    aclp_pkg::cmd_match_t              match;
    aclp_pkg::verdict_t                verdict;
    logic                              cmd_ok;

    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    always_comb begin
        if (q_item.line_start) begin
            ph_e     = aclp_pkg::PH_LETTERS;
            pos_e    = '0;
            first_e  = '0;
            second_e = '0;
            dc_e     = '0;
            acc_e    = '0;
            idx_e    = '0;
            done_e   = 1'b0;
        end else begin
            ph_e     = phase_reg;
            pos_e    = pos_reg;
            first_e  = first_reg;
            second_e = second_reg;
            dc_e     = dc_reg;
            acc_e    = acc_reg;
            idx_e    = idx_reg;
            done_e   = done_reg;
        end
    end

    assign match  = aclp_pkg::cmd_lookup(first_e, second_e);
    assign cmd_ok = (pos_e == aclp_pkg::POS_W'(2)) && q_item.is_space && match.hit;

    // Next phase
    always_comb begin
        phase_next = ph_e;
        if (!done_e) begin
            case (ph_e)
                aclp_pkg::PH_LETTERS: begin
                    if (!q_item.is_lower && cmd_ok) begin
                        phase_next = aclp_pkg::PH_GAP;
                    end
                end
                aclp_pkg::PH_GAP: begin
                    if (!q_item.is_space && q_item.is_hex) begin
                        phase_next = aclp_pkg::PH_DIGITS;
                    end
                end
                aclp_pkg::PH_DIGITS: begin
                    if (!q_item.is_hex && dc_e <= aclp_pkg::DC_LIMIT &&
                        (q_item.is_space || q_item.is_end)) begin
                        phase_next = aclp_pkg::PH_TAIL;
                    end
                end
                default: begin
                    phase_next = ph_e;
                end
            endcase
        end
    end

    // Verdict and line datapath
    always_comb begin
        verdict     = aclp_pkg::VERD_NONE;
        pos_next    = pos_e;
        first_next  = first_e;
        second_next = second_e;
        dc_next     = dc_e;
        acc_next    = acc_e;
        idx_next    = idx_e;
        if (!done_e) begin
            case (ph_e)
                aclp_pkg::PH_LETTERS: begin
                    if (q_item.is_lower) begin
                        if (pos_e == '0) begin
                            first_next = q_item.ch;
                        end else if (pos_e == aclp_pkg::POS_W'(1)) begin
                            second_next = q_item.ch;
                        end
                    end else if (cmd_ok) begin
                        idx_next = match.idx;
                    end else begin
                        verdict = aclp_pkg::VERD_REJECT;
                    end
                end
                aclp_pkg::PH_GAP: begin
                    if (q_item.is_space) begin
                        verdict = aclp_pkg::VERD_NONE;
                    end else if (q_item.is_hex) begin
                        acc_next = aclp_pkg::ARG_W'(q_item.hex_val);
                        dc_next  = aclp_pkg::DC_W'(1);
                    end else begin
                        verdict = aclp_pkg::VERD_REJECT;
                    end
                end
                aclp_pkg::PH_DIGITS: begin
                    if (q_item.is_hex) begin
                        acc_next = {acc_e[aclp_pkg::ARG_W-5:0], q_item.hex_val};
                        if (dc_e != aclp_pkg::DC_MAX) begin
                            dc_next = dc_e + 1'b1;
                        end
                    end else if (dc_e <= aclp_pkg::DC_LIMIT) begin
                        if (q_item.is_end) begin
                            verdict = aclp_pkg::VERD_ACCEPT;
                        end else if (!q_item.is_space) begin
                            verdict = aclp_pkg::VERD_REJECT;
                        end
                    end
                end
                default: begin
                    if (q_item.is_end) begin
                        verdict = aclp_pkg::VERD_ACCEPT;
                    end else if (!q_item.is_space) begin
                        verdict = aclp_pkg::VERD_REJECT;
                    end
                end
            endcase
            // The last byte of the window always rejects
            if (pos_e >= aclp_pkg::POS_LAST) begin
                verdict = aclp_pkg::VERD_REJECT;
            end else begin
                pos_next = pos_e + 1'b1;
            end
        end
        done_next = done_e || (verdict != aclp_pkg::VERD_NONE);
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (q_pop && verdict != aclp_pkg::VERD_NONE) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= aclp_pkg::PH_LETTERS;
            pos_reg       <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            dc_reg        <= '0;
            acc_reg       <= '0;
            idx_reg       <= '0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                dc_reg     <= dc_next;
                acc_reg    <= acc_next;
                idx_reg    <= idx_next;
                done_reg   <= done_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && verdict != aclp_pkg::VERD_NONE) begin
            out_acc_reg <= (verdict == aclp_pkg::VERD_ACCEPT);
            out_idx_reg <= (verdict == aclp_pkg::VERD_ACCEPT) ? idx_e : '0;
            out_arg_reg <= (verdict == aclp_pkg::VERD_ACCEPT) ? acc_e : '0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_accepted      = out_acc_reg;
    assign m_command_index = out_idx_reg;
    assign m_argument      = out_arg_reg;

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (m_command_index == '0 && m_argument == '0))
        else $error("rejected line carries nonzero fields");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (m_command_index < aclp_pkg::IDX_W'(aclp_pkg::CMD_COUNT)))
        else $error("command index outside table");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= aclp_pkg::POS_LAST)
        else $error("line position beyond window");

endmodule

`default_nettype wire
